### src/dcc_command_packet_builder_top_assert.svh
// assertion macros for the dcc packet builder
`ifndef DCC_COMMAND_PACKET_BUILDER_TOP_ASSERT_SVH
`define DCC_COMMAND_PACKET_BUILDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define DCC_CPB_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dcc_cpb check failed");
// checked during reset as well
`define DCC_CPB_ASSERT_RST(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("dcc_cpb reset check failed");
`else
`define DCC_CPB_ASSERT(name, prop)
`define DCC_CPB_ASSERT_RST(name, prop)
`endif

`endif

### src/dcc_cpb_pkg.sv
package dcc_cpb_pkg;

   localparam int PKT_BYTES = 5;

   typedef enum logic [2:0] {
      CMD_RESET       = 3'd0,
      CMD_SPEED14     = 3'd1,
      CMD_SPEED28     = 3'd2,
      CMD_SPEED126    = 3'd3,
      CMD_FUNCTIONS   = 3'd4,
      CMD_VERIFY_BIT  = 3'd5,
      CMD_VERIFY_BYTE = 3'd6,
      CMD_WRITE_BYTE  = 3'd7
   } dcc_cpb_cmd_type;

   localparam logic [13:0] SHORT_ADDR_LIMIT = 14'd128;
   localparam logic [7:0]  LONG_ADDR_PREFIX = 8'hC0;
   localparam logic [7:0]  SPEED_FWD        = 8'h60;
   localparam logic [7:0]  SPEED_REV        = 8'h40;
   localparam logic [7:0]  ADV_OP           = 8'h3F;
   localparam logic [7:0]  ADV_FWD          = 8'h80;
   localparam logic [7:0]  FG1_OP           = 8'h80;
   localparam logic [7:0]  FG2_OP           = 8'hB0;
   localparam logic [7:0]  FG3_OP           = 8'hA0;
   localparam logic [7:0]  SVC_VERIFY_BIT   = 8'h78;
   localparam logic [7:0]  SVC_VERIFY_BYTE  = 8'h74;
   localparam logic [7:0]  SVC_WRITE_BYTE   = 8'h7C;
   localparam logic [7:0]  BIT_MANIP_OP     = 8'hE0;
   localparam logic [7:0]  SPEED14_MAX      = 8'd15;
   localparam logic [7:0]  SPEED28_MAX      = 8'd31;
   localparam logic [7:0]  SPEED126_MAX     = 8'd127;
   localparam logic [7:0]  FUNC_SMALL_MAX   = 8'd31;
   localparam logic [3:0]  GROUP_SMALL_MAX  = 4'd3;
   localparam logic [3:0]  GROUP_MAX        = 4'd10;
   localparam logic [1:0]  DIR_FORWARD      = 2'd0;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [13:0] loco_address;
      logic [7:0]  speed;
      logic [1:0]  direction;
      logic        light;
      logic [3:0]  group;
      logic [7:0]  function_bits;
      logic [10:0] cv_number;
      logic [7:0]  cv_value;
      logic [2:0]  bit_position;
   } dcc_cpb_req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last;
      logic       rejected;
   } dcc_cpb_rsp_type;

   // built packet: bytes in transmit order, checksum included
   typedef struct packed {
      logic [PKT_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      rejected;
   } dcc_cpb_packet_type;

   // command byte for function groups 4 to 10
   function automatic logic [7:0] ext_group_cmd(input logic [3:0] grp);
      logic [7:0] code;
      case (grp)
         4'd4:    code = 8'hDE;
         4'd5:    code = 8'hDF;
         4'd6:    code = 8'hD8;
         4'd7:    code = 8'hD9;
         4'd8:    code = 8'hDA;
         4'd9:    code = 8'hDB;
         4'd10:   code = 8'hDC;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

### src/dcc_cpb_builder.sv
module dcc_cpb_builder
   import dcc_cpb_pkg::*;
(
   input  dcc_cpb_req_type    req,
   output dcc_cpb_packet_type pkt
);

   logic [PKT_BYTES-1:0][7:0] body;
   logic [2:0]                n;
   logic                      rej;
   logic                      use_addr;
   logic                      long_addr;
   logic [7:0]                pl0;
   logic [7:0]                pl1;
   logic                      pl_two;
   logic [9:0]                svc_a;
   logic [7:0]                svc_base;
   logic [7:0]                svc_third;
   logic [7:0]                csum;
   logic                      dir_fwd;
   logic                      dir_bad;

   assign long_addr = !(req.loco_address < SHORT_ADDR_LIMIT);
   assign dir_fwd   = (req.direction == DIR_FORWARD);
   assign dir_bad   = req.direction[1];
   // cv number 0 wraps to 1024
   assign svc_a     = req.cv_number[9:0] - 10'd1;

   always_comb begin
      body      = '0;
      n         = 3'd0;
      rej       = 1'b0;
      use_addr  = 1'b0;
      pl0       = 8'h00;
      pl1       = 8'h00;
      pl_two    = 1'b0;
      svc_base  = SVC_WRITE_BYTE;
      svc_third = req.cv_value;
      case (dcc_cpb_cmd_type'(req.cmd))
         CMD_RESET: begin
            n = 3'd2;
         end
         CMD_SPEED14: begin
            rej      = (req.speed > SPEED14_MAX) || dir_bad;
            use_addr = 1'b1;
            pl0      = (dir_fwd ? SPEED_FWD : SPEED_REV)
                     | {3'b000, req.light, req.speed[3:0]};
         end
         CMD_SPEED28: begin
            // speed bit 0 is the intermediate step bit
            rej      = (req.speed > SPEED28_MAX) || dir_bad;
            use_addr = 1'b1;
            pl0      = (dir_fwd ? SPEED_FWD : SPEED_REV)
                     | {3'b000, req.speed[0], req.speed[4:1]};
         end
         CMD_SPEED126: begin
            rej      = (req.speed > SPEED126_MAX) || dir_bad;
            use_addr = 1'b1;
            pl0      = ADV_OP;
            pl1      = (dir_fwd ? ADV_FWD : 8'h00) | {1'b0, req.speed[6:0]};
            pl_two   = 1'b1;
         end
         CMD_FUNCTIONS: begin
            rej      = (req.group == 4'd0) || (req.group > GROUP_MAX)
                     || ((req.group <= GROUP_SMALL_MAX)
                         && (req.function_bits > FUNC_SMALL_MAX));
            use_addr = 1'b1;
            if (req.group == 4'd1) begin
               pl0 = FG1_OP | req.function_bits;
            end else if (req.group == 4'd2) begin
               pl0 = FG2_OP | {4'h0, req.function_bits[3:0]};
            end else if (req.group == 4'd3) begin
               pl0 = FG3_OP | {4'h0, req.function_bits[3:0]};
            end else begin
               pl0    = ext_group_cmd(req.group);
               pl1    = req.function_bits;
               pl_two = 1'b1;
            end
         end
         CMD_VERIFY_BIT: begin
            svc_base  = SVC_VERIFY_BIT;
            svc_third = BIT_MANIP_OP
                      | {4'h0, (req.cv_value != 8'h00), req.bit_position};
         end
         CMD_VERIFY_BYTE: begin
            svc_base = SVC_VERIFY_BYTE;
         end
         CMD_WRITE_BYTE: begin
            svc_base = SVC_WRITE_BYTE;
         end
         default: begin
            rej = 1'b1;
         end
      endcase

      if (use_addr) begin
         if (long_addr) begin
            body[0] = LONG_ADDR_PREFIX | {2'b00, req.loco_address[13:8]};
            body[1] = req.loco_address[7:0];
            body[2] = pl0;
            body[3] = pl_two ? pl1 : 8'h00;
            n       = pl_two ? 3'd4 : 3'd3;
         end else begin
            body[0] = {1'b0, req.loco_address[6:0]};
            body[1] = pl0;
            body[2] = pl_two ? pl1 : 8'h00;
            n       = pl_two ? 3'd3 : 3'd2;
         end
      end else if (req.cmd != CMD_RESET) begin
         body[0] = svc_base | {6'b000000, svc_a[9:8]};
         body[1] = svc_a[7:0];
         body[2] = svc_third;
         n       = 3'd3;
      end
   end

   // unused body bytes are zero, so a plain xor gives the checksum
   assign csum = body[0] ^ body[1] ^ body[2] ^ body[3] ^ body[4];

   always_comb begin
      pkt = '0;
      if (rej) begin
         pkt.count    = 3'd1;
         pkt.rejected = 1'b1;
      end else begin
         for (int i = 0; i < PKT_BYTES; i++) begin
            if (3'(i) < n) begin
               pkt.bytes[i] = body[i];
            end else if (3'(i) == n) begin
               pkt.bytes[i] = csum;
            end
         end
         pkt.count = n + 3'd1;
      end
   end

endmodule

### src/dcc_cpb_emitter.sv
module dcc_cpb_emitter
   import dcc_cpb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dcc_cpb_packet_type pkt,
   output logic               can_load,
   output logic               rsp_strobe,
   output dcc_cpb_rsp_type    rsp_data
);

   dcc_cpb_packet_type pkt_ff, pkt_in;
   logic [2:0]         idx_ff, idx_in;
   logic               active_ff, active_in;
   logic               last_byte;

   assign last_byte = (idx_ff == pkt_ff.count - 3'd1);
   // next packet may follow directly behind the final byte
   assign can_load  = !active_ff || last_byte;

   always_comb begin
      pkt_in    = pkt_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (load) begin
         pkt_in    = pkt;
         idx_in    = 3'd0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (last_byte) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 3'd0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign rsp_strobe           = active_ff;
   assign rsp_data.packet_byte = pkt_ff.bytes[idx_ff];
   assign rsp_data.last        = last_byte;
   assign rsp_data.rejected    = pkt_ff.rejected;

endmodule

### src/dcc_command_packet_builder_top.sv
// DCC command packet builder
//
// A request is taken on req_data at a rising edge where start is high and
// busy is low. It builds one DCC packet: the address (one byte below 128,
// two bytes otherwise) or the service-mode cv address, the command bytes,
// and an xor checksum. Bytes leave on rsp_data one per cycle, each marked
// by rsp_strobe for a single cycle; the checksum byte has last set. An
// invalid request gives one result with rejected and last set and a zero
// byte.
// The request is registered in the input register and then loaded into
// the byte serializer, whose register shows the first byte. A request
// producing n results (1 to 5) holds the serializer until its final byte
// is shown; one request waits in the input register while the previous
// packet drains, and the next is taken in the cycle its predecessor's
// final byte is shown.
// The receiver cannot stall: every strobed byte counts as transferred.
// Synchronous reset empties the input register and the serializer; no
// result is shown in the cycle after reset.
`include "dcc_command_packet_builder_top_assert.svh"

module dcc_command_packet_builder_top
   import dcc_cpb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  dcc_cpb_req_type req_data,
   output logic            rsp_strobe,
   output dcc_cpb_rsp_type rsp_data
);

   dcc_cpb_req_type    req_ff, req_in;
   logic               req_valid_ff, req_valid_in;
   logic               accept;
   logic               load;
   logic               can_load;
   dcc_cpb_packet_type pkt;

   assign load   = req_valid_ff && can_load;
   assign busy   = req_valid_ff && !can_load;
   assign accept = start && !busy;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (accept) begin
         req_in       = req_data;
         req_valid_in = 1'b1;
      end else if (load) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   dcc_cpb_builder u_builder (
      .req (req_ff),
      .pkt (pkt)
   );

   dcc_cpb_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .pkt        (pkt),
      .can_load   (can_load),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `DCC_CPB_ASSERT_RST(a_reset_quiet, reset |=> !rsp_strobe)
   `DCC_CPB_ASSERT(a_no_overwrite, accept && req_valid_ff |-> load)
   `DCC_CPB_ASSERT(a_load_shows, load |=> rsp_strobe)
   `DCC_CPB_ASSERT(a_reject_form, rsp_strobe && rsp_data.rejected |-> rsp_data.last && rsp_data.packet_byte == 8'd0)

endmodule
